>>> design/icmp_rc_pkg.sv
`default_nettype none

package icmp_rc_pkg;

   localparam logic [3:0] VERDICT_SHORT         = 4'd0;
   localparam logic [3:0] VERDICT_NOT_ICMP      = 4'd1;
   localparam logic [3:0] VERDICT_BAD_CHECKSUM  = 4'd2;
   localparam logic [3:0] VERDICT_DELIVER       = 4'd3;
   localparam logic [3:0] VERDICT_ECHO_REPLY    = 4'd4;
   localparam logic [3:0] VERDICT_BAD_CODE      = 4'd5;
   localparam logic [3:0] VERDICT_UNHANDLED     = 4'd6;
   localparam logic [3:0] VERDICT_EMB_SHORT     = 4'd7;
   localparam logic [3:0] VERDICT_TCP_ERR       = 4'd8;
   localparam logic [3:0] VERDICT_UDP_ERR       = 4'd9;
   localparam logic [3:0] VERDICT_ICMP_ERR      = 4'd10;
   localparam logic [3:0] VERDICT_UNKNOWN_EMB   = 4'd11;

   localparam logic [1:0] KIND_NONE             = 2'd0;
   localparam logic [1:0] KIND_DEST_UNREACH     = 2'd1;
   localparam logic [1:0] KIND_TTL_EXCEEDED     = 2'd2;

   localparam logic [7:0] TYPE_ECHO_REPLY       = 8'd0;
   localparam logic [7:0] TYPE_DEST_UNREACH     = 8'd3;
   localparam logic [7:0] TYPE_ECHO_REQUEST     = 8'd8;
   localparam logic [7:0] TYPE_TIME_EXCEEDED    = 8'd11;

   localparam logic [7:0] CODE_PORT_UNREACH     = 8'd3;
   localparam logic [7:0] CODE_TTL_IN_TRANSIT   = 8'd0;
   localparam logic [7:0] CODE_FRAG_REASSEMBLY  = 8'd1;

   localparam logic [7:0] PROTO_ICMP            = 8'd1;
   localparam logic [7:0] PROTO_TCP             = 8'd6;
   localparam logic [7:0] PROTO_UDP             = 8'd17;

   localparam logic [1:0] CSR_ICMP_MIN          = 2'd0;
   localparam logic [1:0] CSR_TCP_MIN           = 2'd1;
   localparam logic [1:0] CSR_UDP_MIN           = 2'd2;

   localparam logic [15:0] HDR_BYTES            = 16'd8;
   localparam logic [15:0] IPV4_MIN_HDR         = 16'd20;
   localparam logic [15:0] COUNT_MAX            = 16'hFFFF;
   localparam logic [15:0] SUM_GOOD             = 16'hFFFF;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
      logic [7:0] ip_protocol;
   } req_type;

   typedef struct packed {
      logic [3:0]  verdict;
      logic [1:0]  error_kind;
      logic [7:0]  msg_type;
      logic [7:0]  msg_code;
      logic [15:0] reply_checksum;
      logic [7:0]  embedded_proto;
      logic [15:0] embedded_src_port;
      logic [15:0] embedded_dst_port;
      logic [31:0] embedded_seq;
      logic [15:0] embedded_payload_len;
   } rsp_type;

   typedef struct packed {
      logic [15:0] byte_count;
      logic [15:0] running_sum;
      logic [15:0] body_sum;
      logic [7:0]  high_byte;
      logic [7:0]  type_seen;
      logic [7:0]  code_seen;
      logic [15:0] checksum_field;
      logic [7:0]  proto_seen;
      logic [5:0]  inner_hdr_len;
      logic [7:0]  inner_proto;
      logic [15:0] port_a;
      logic [15:0] port_b;
      logic [31:0] seq_word;
   } msg_state_type;

   typedef struct packed {
      logic [7:0] icmp_min;
      logic [7:0] tcp_min;
      logic [7:0] udp_min;
   } csr_type;

endpackage

`default_nettype wire

>>> design/icmp_rc_verdict.sv
`default_nettype none

module icmp_rc_verdict (
   input  icmp_rc_pkg::msg_state_type st,
   input  icmp_rc_pkg::csr_type       csr,
   output icmp_rc_pkg::rsp_type       rsp
);

   logic [15:0] quoted_len;
   logic [15:0] rest;
   logic [15:0] hdr_len;
   logic [3:0]  emb_verdict;
   logic [3:0]  verdict;
   logic [1:0]  kind;
   logic [15:0] reply;

   assign hdr_len    = {10'd0, st.inner_hdr_len};
   assign quoted_len = st.byte_count - icmp_rc_pkg::HDR_BYTES;
   assign rest       = quoted_len - hdr_len;

   // quoted packet checks
   always_comb begin
      if (quoted_len < icmp_rc_pkg::IPV4_MIN_HDR || quoted_len < hdr_len) begin
         emb_verdict = icmp_rc_pkg::VERDICT_EMB_SHORT;
      end else begin
         case (st.inner_proto)
            icmp_rc_pkg::PROTO_ICMP: begin
               emb_verdict = (rest < {8'd0, csr.icmp_min}) ? icmp_rc_pkg::VERDICT_EMB_SHORT
                                                          : icmp_rc_pkg::VERDICT_ICMP_ERR;
            end
            icmp_rc_pkg::PROTO_TCP: begin
               emb_verdict = (rest < {8'd0, csr.tcp_min}) ? icmp_rc_pkg::VERDICT_EMB_SHORT
                                                         : icmp_rc_pkg::VERDICT_TCP_ERR;
            end
            icmp_rc_pkg::PROTO_UDP: begin
               emb_verdict = (rest < {8'd0, csr.udp_min}) ? icmp_rc_pkg::VERDICT_EMB_SHORT
                                                         : icmp_rc_pkg::VERDICT_UDP_ERR;
            end
            default: begin
               emb_verdict = icmp_rc_pkg::VERDICT_UNKNOWN_EMB;
            end
         endcase
      end
   end

   always_comb begin
      kind  = icmp_rc_pkg::KIND_NONE;
      reply = 16'd0;
      if (st.byte_count < icmp_rc_pkg::HDR_BYTES) begin
         verdict = icmp_rc_pkg::VERDICT_SHORT;
      end else if (st.proto_seen != icmp_rc_pkg::PROTO_ICMP) begin
         verdict = icmp_rc_pkg::VERDICT_NOT_ICMP;
      end else if (st.checksum_field != 16'd0 && st.running_sum != icmp_rc_pkg::SUM_GOOD) begin
         verdict = icmp_rc_pkg::VERDICT_BAD_CHECKSUM;
      end else begin
         case (st.type_seen)
            icmp_rc_pkg::TYPE_ECHO_REPLY: begin
               verdict = (st.code_seen == 8'd0) ? icmp_rc_pkg::VERDICT_DELIVER
                                                : icmp_rc_pkg::VERDICT_BAD_CODE;
            end
            icmp_rc_pkg::TYPE_ECHO_REQUEST: begin
               if (st.code_seen == 8'd0) begin
                  verdict = icmp_rc_pkg::VERDICT_ECHO_REPLY;
                  reply   = ~st.body_sum;
               end else begin
                  verdict = icmp_rc_pkg::VERDICT_BAD_CODE;
               end
            end
            icmp_rc_pkg::TYPE_DEST_UNREACH: begin
               if (st.code_seen == icmp_rc_pkg::CODE_PORT_UNREACH) begin
                  kind    = icmp_rc_pkg::KIND_DEST_UNREACH;
                  verdict = emb_verdict;
               end else if (st.code_seen inside {[8'd0:8'd5]}) begin
                  verdict = icmp_rc_pkg::VERDICT_UNHANDLED;
               end else begin
                  verdict = icmp_rc_pkg::VERDICT_BAD_CODE;
               end
            end
            icmp_rc_pkg::TYPE_TIME_EXCEEDED: begin
               if (st.code_seen == icmp_rc_pkg::CODE_TTL_IN_TRANSIT) begin
                  kind    = icmp_rc_pkg::KIND_TTL_EXCEEDED;
                  verdict = emb_verdict;
               end else if (st.code_seen == icmp_rc_pkg::CODE_FRAG_REASSEMBLY) begin
                  verdict = icmp_rc_pkg::VERDICT_UNHANDLED;
               end else begin
                  verdict = icmp_rc_pkg::VERDICT_BAD_CODE;
               end
            end
            default: begin
               verdict = icmp_rc_pkg::VERDICT_DELIVER;
            end
         endcase
      end
   end

   always_comb begin
      rsp                = '0;
      rsp.verdict        = verdict;
      rsp.error_kind     = kind;
      rsp.msg_type       = st.type_seen;
      rsp.msg_code       = st.code_seen;
      rsp.reply_checksum = reply;
      if (verdict >= icmp_rc_pkg::VERDICT_TCP_ERR) begin
         rsp.embedded_proto       = st.inner_proto;
         rsp.embedded_src_port    = st.port_a;
         rsp.embedded_dst_port    = st.port_b;
         rsp.embedded_seq         = st.seq_word;
         rsp.embedded_payload_len = rest;
      end
   end

endmodule

`default_nettype wire

>>> design/icmp_receive_classifier.sv
// a request with last set passes the input register, the state register and the response register in turn
// throughput: one request per cycle while no response is stalled, set by the single running-sum add per byte
// a final request waits in the state stage only while a previous response is stalled
// reset: synchronous, active high; clears message state, valid flags, and sets
// all three minimum-payload registers to 8
`default_nettype none

module icmp_receive_classifier (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  icmp_rc_pkg::req_type req_payload,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output icmp_rc_pkg::rsp_type rsp_payload,
   input  wire                  csr_write_enable,
   input  wire [1:0]            csr_index,
   input  wire [7:0]            csr_write_data
);

   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   icmp_rc_pkg::csr_type       csr_ff;
   icmp_rc_pkg::csr_type       csr_in;
   logic                       in_valid_ff;
   logic                       in_valid_in;
   icmp_rc_pkg::req_type       in_req_ff;
   icmp_rc_pkg::req_type       in_req_in;
   icmp_rc_pkg::msg_state_type state_ff;
   icmp_rc_pkg::msg_state_type state_in;
   icmp_rc_pkg::msg_state_type cur;
   icmp_rc_pkg::msg_state_type nxt;
   logic                       finish_ff;
   logic                       finish_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   icmp_rc_pkg::rsp_type       rsp_ff;
   icmp_rc_pkg::rsp_type       rsp_in;
   icmp_rc_pkg::rsp_type       verdict_rsp;

   logic        hold;
   logic        advance;
   logic        req_accept;
   logic [15:0] idx;
   logic [5:0]  hdr;
   logic [16:0] off;
   logic [15:0] word;
   logic        have_word;
   logic        body_ok;
   logic [7:0]  b;

   assign hold       = finish_ff && rsp_valid_ff && rsp_stall;
   assign advance    = in_valid_ff && !hold;
   assign req_stall  = in_valid_ff && hold;
   assign req_accept = req_valid && !req_stall;

   // configuration
   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         case (csr_index)
            icmp_rc_pkg::CSR_ICMP_MIN: csr_in.icmp_min = csr_write_data;
            icmp_rc_pkg::CSR_TCP_MIN:  csr_in.tcp_min  = csr_write_data;
            icmp_rc_pkg::CSR_UDP_MIN:  csr_in.udp_min  = csr_write_data;
            default:                   csr_in = csr_ff;
         endcase
      end
   end

   // input stage
   always_comb begin
      in_req_in   = in_req_ff;
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_req_in   = req_payload;
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // a finished message is seen by the next byte as cleared state
   assign cur = finish_ff ? '0 : state_ff;
   assign b   = in_req_ff.data_byte;
   assign idx = cur.byte_count;
   assign hdr = (idx == icmp_rc_pkg::HDR_BYTES) ? {b[3:0], 2'b00} : cur.inner_hdr_len;
   assign off = {1'b0, idx} - {1'b0, icmp_rc_pkg::HDR_BYTES} - {11'd0, hdr};

   always_comb begin
      nxt       = cur;
      word      = 16'd0;
      have_word = 1'b0;
      body_ok   = 1'b0;
      if (idx != icmp_rc_pkg::COUNT_MAX) begin
         if (idx == 16'd0) begin
            nxt.proto_seen = in_req_ff.ip_protocol;
            nxt.type_seen  = b;
         end
         if (idx == 16'd1) nxt.code_seen = b;
         if (idx == 16'd2) nxt.checksum_field[15:8] = b;
         if (idx == 16'd3) nxt.checksum_field[7:0] = b;
         nxt.inner_hdr_len = hdr;
         if (idx == icmp_rc_pkg::HDR_BYTES + 16'd9) nxt.inner_proto = b;
         // transport bytes right after the quoted header
         if (!off[16] && off[15:3] == 13'd0) begin
            case (off[2:0])
               3'd0:    nxt.port_a[15:8]   = b;
               3'd1:    nxt.port_a[7:0]    = b;
               3'd2:    nxt.port_b[15:8]   = b;
               3'd3:    nxt.port_b[7:0]    = b;
               3'd4:    nxt.seq_word[31:24] = b;
               3'd5:    nxt.seq_word[23:16] = b;
               3'd6:    nxt.seq_word[15:8]  = b;
               default: nxt.seq_word[7:0]   = b;
            endcase
         end
         // odd final byte is padded with a zero low byte
         if (idx[0]) begin
            word      = {cur.high_byte, b};
            have_word = 1'b1;
            body_ok   = idx >= 16'd5;
         end else if (in_req_ff.last) begin
            word      = {b, 8'd0};
            have_word = 1'b1;
            body_ok   = idx >= 16'd4;
         end else begin
            nxt.high_byte = b;
         end
         if (have_word) begin
            nxt.running_sum = oc_add(cur.running_sum, word);
            if (body_ok) nxt.body_sum = oc_add(cur.body_sum, word);
         end
         nxt.byte_count = idx + 16'd1;
      end
   end

   // state stage
   always_comb begin
      state_in  = state_ff;
      finish_in = finish_ff;
      if (advance) begin
         state_in  = nxt;
         finish_in = in_req_ff.last;
      end else if (!hold) begin
         state_in  = cur;
         finish_in = 1'b0;
      end
   end

   icmp_rc_verdict u_verdict (
      .st  (state_ff),
      .csr (csr_ff),
      .rsp (verdict_rsp)
   );

   // response register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (finish_ff && !hold) begin
         rsp_in       = verdict_rsp;
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= '{icmp_min: 8'd8, tcp_min: 8'd8, udp_min: 8'd8};
         in_valid_ff  <= 1'b0;
         state_ff     <= '0;
         finish_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         csr_ff       <= csr_in;
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         finish_ff    <= finish_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_req_ff <= in_req_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_finish_to_rsp: assert property (@(posedge clock) disable iff (reset)
      finish_ff && !hold |=> rsp_valid)
      else $error("finished message did not reach the response register");

   a_embedded_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.verdict < icmp_rc_pkg::VERDICT_TCP_ERR |->
      rsp_payload.embedded_proto == 8'd0 && rsp_payload.embedded_src_port == 16'd0 &&
      rsp_payload.embedded_dst_port == 16'd0 && rsp_payload.embedded_seq == 32'd0 &&
      rsp_payload.embedded_payload_len == 16'd0)
      else $error("embedded fields set on a non-error verdict");

   a_kind_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_payload.error_kind != icmp_rc_pkg::KIND_NONE) ==
      (rsp_payload.verdict >= icmp_rc_pkg::VERDICT_EMB_SHORT)))
      else $error("error kind does not match verdict");

   a_verdict_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.verdict <= icmp_rc_pkg::VERDICT_UNKNOWN_EMB)
      else $error("verdict out of range");
`endif

endmodule

`default_nettype wire

>>> test/tb_icmp_receive_classifier.sv
`default_nettype none

module tb_icmp_receive_classifier;

   localparam logic [7:0] CODE_DEFAULT         = 8'd0;
   localparam logic [7:0] CODE_LAST_UNHANDLED  = 8'd5;
   localparam int         RANDOM_PHASE_BYTES   = 90;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   icmp_rc_pkg::req_type  req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   icmp_rc_pkg::rsp_type  rsp_payload;
   logic                  csr_write_enable = 1'b0;
   logic [1:0]            csr_index = icmp_rc_pkg::CSR_ICMP_MIN;
   logic [7:0]            csr_write_data = 8'd0;

   // predicted classifier state
   logic [15:0] msg_len = '0;
   logic [15:0] csum_acc = '0;
   logic [15:0] body_acc = '0;
   logic [7:0]  pending_hi = '0;
   logic [7:0]  cap_type = '0;
   logic [7:0]  cap_code = '0;
   logic [15:0] cap_csum = '0;
   logic [7:0]  cap_proto = '0;
   logic [5:0]  quoted_ihl = '0;
   logic [7:0]  quoted_proto = '0;
   logic [15:0] cap_sport = '0;
   logic [15:0] cap_dport = '0;
   logic [31:0] cap_seq = '0;
   logic [7:0]  min_icmp_payload = 8'd8;
   logic [7:0]  min_tcp_payload = 8'd8;
   logic [7:0]  min_udp_payload = 8'd8;

   icmp_rc_pkg::rsp_type verdict_queue[$];
   logic [7:0]           msg_bytes[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int error_count = 0;
   int bytes_sent = 0;
   int messages_sent = 0;
   int verdicts_checked = 0;

   icmp_receive_classifier uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [3:0] embedded_verdict(output int payload);
      int quoted_len;
      int rest;
      payload = 0;
      quoted_len = int'(msg_len) - int'(icmp_rc_pkg::HDR_BYTES);
      if (quoted_len < int'(icmp_rc_pkg::IPV4_MIN_HDR) || quoted_len < int'(quoted_ihl))
         return icmp_rc_pkg::VERDICT_EMB_SHORT;
      rest = quoted_len - int'(quoted_ihl);
      payload = rest;
      if (quoted_proto == icmp_rc_pkg::PROTO_ICMP)
         return (rest < int'(min_icmp_payload)) ? icmp_rc_pkg::VERDICT_EMB_SHORT
                                                 : icmp_rc_pkg::VERDICT_ICMP_ERR;
      if (quoted_proto == icmp_rc_pkg::PROTO_TCP)
         return (rest < int'(min_tcp_payload)) ? icmp_rc_pkg::VERDICT_EMB_SHORT
                                                : icmp_rc_pkg::VERDICT_TCP_ERR;
      if (quoted_proto == icmp_rc_pkg::PROTO_UDP)
         return (rest < int'(min_udp_payload)) ? icmp_rc_pkg::VERDICT_EMB_SHORT
                                                : icmp_rc_pkg::VERDICT_UDP_ERR;
      return icmp_rc_pkg::VERDICT_UNKNOWN_EMB;
   endfunction

   task automatic classify_byte(icmp_rc_pkg::req_type r);
      int idx;
      int off;
      int word_start;
      int payload;
      bit have_word;
      logic [15:0] word;
      icmp_rc_pkg::rsp_type want;
      have_word = 1'b0;
      word = '0;
      word_start = 0;
      payload = 0;
      if (msg_len != icmp_rc_pkg::COUNT_MAX) begin
         idx = msg_len;
         if (idx == 0) begin
            cap_proto = r.ip_protocol;
            cap_type = r.data_byte;
         end
         if (idx == 1) cap_code = r.data_byte;
         if (idx == 2) cap_csum[15:8] = r.data_byte;
         if (idx == 3) cap_csum[7:0] = r.data_byte;
         if (idx == icmp_rc_pkg::HDR_BYTES) quoted_ihl = {r.data_byte[3:0], 2'b00};
         if (idx == icmp_rc_pkg::HDR_BYTES + 9) quoted_proto = r.data_byte;
         if (idx >= int'(icmp_rc_pkg::HDR_BYTES) + int'(quoted_ihl)) begin
            off = idx - int'(icmp_rc_pkg::HDR_BYTES) - int'(quoted_ihl);
            if (off == 0) cap_sport[15:8] = r.data_byte;
            else if (off == 1) cap_sport[7:0] = r.data_byte;
            else if (off == 2) cap_dport[15:8] = r.data_byte;
            else if (off == 3) cap_dport[7:0] = r.data_byte;
            else if (off < 8) cap_seq[8 * (7 - off) +: 8] = r.data_byte;
         end
         if (idx % 2 == 1) begin
            word = {pending_hi, r.data_byte};
            word_start = idx - 1;
            have_word = 1'b1;
         end else if (r.last) begin
            word = {r.data_byte, 8'h00};
            word_start = idx;
            have_word = 1'b1;
         end else begin
            pending_hi = r.data_byte;
         end
         if (have_word) begin
            csum_acc = ones_add(csum_acc, word);
            if (word_start >= 4) body_acc = ones_add(body_acc, word);
         end
         msg_len = msg_len + 16'd1;
      end
      if (r.last) begin
         want = '0;
         want.msg_type = cap_type;
         want.msg_code = cap_code;
         want.error_kind = icmp_rc_pkg::KIND_NONE;
         if (msg_len < icmp_rc_pkg::HDR_BYTES) begin
            want.verdict = icmp_rc_pkg::VERDICT_SHORT;
         end else if (cap_proto != icmp_rc_pkg::PROTO_ICMP) begin
            want.verdict = icmp_rc_pkg::VERDICT_NOT_ICMP;
         end else if (cap_csum != 16'd0 && csum_acc != icmp_rc_pkg::SUM_GOOD) begin
            want.verdict = icmp_rc_pkg::VERDICT_BAD_CHECKSUM;
         end else if (cap_type == icmp_rc_pkg::TYPE_ECHO_REPLY) begin
            want.verdict = (cap_code == CODE_DEFAULT) ? icmp_rc_pkg::VERDICT_DELIVER
                                                      : icmp_rc_pkg::VERDICT_BAD_CODE;
         end else if (cap_type == icmp_rc_pkg::TYPE_ECHO_REQUEST) begin
            if (cap_code == CODE_DEFAULT) begin
               want.verdict = icmp_rc_pkg::VERDICT_ECHO_REPLY;
               want.reply_checksum = ~body_acc;
            end else begin
               want.verdict = icmp_rc_pkg::VERDICT_BAD_CODE;
            end
         end else if (cap_type == icmp_rc_pkg::TYPE_DEST_UNREACH) begin
            if (cap_code == icmp_rc_pkg::CODE_PORT_UNREACH) begin
               want.error_kind = icmp_rc_pkg::KIND_DEST_UNREACH;
               want.verdict = embedded_verdict(payload);
            end else if (cap_code <= CODE_LAST_UNHANDLED) begin
               want.verdict = icmp_rc_pkg::VERDICT_UNHANDLED;
            end else begin
               want.verdict = icmp_rc_pkg::VERDICT_BAD_CODE;
            end
         end else if (cap_type == icmp_rc_pkg::TYPE_TIME_EXCEEDED) begin
            if (cap_code == icmp_rc_pkg::CODE_TTL_IN_TRANSIT) begin
               want.error_kind = icmp_rc_pkg::KIND_TTL_EXCEEDED;
               want.verdict = embedded_verdict(payload);
            end else if (cap_code == icmp_rc_pkg::CODE_FRAG_REASSEMBLY) begin
               want.verdict = icmp_rc_pkg::VERDICT_UNHANDLED;
            end else begin
               want.verdict = icmp_rc_pkg::VERDICT_BAD_CODE;
            end
         end else begin
            want.verdict = icmp_rc_pkg::VERDICT_DELIVER;
         end
         if (want.verdict >= icmp_rc_pkg::VERDICT_TCP_ERR) begin
            want.embedded_proto = quoted_proto;
            want.embedded_src_port = cap_sport;
            want.embedded_dst_port = cap_dport;
            want.embedded_seq = cap_seq;
            want.embedded_payload_len = payload[15:0];
         end
         verdict_queue.push_back(want);
         msg_len = '0;
         csum_acc = '0;
         body_acc = '0;
         pending_hi = '0;
         cap_type = '0;
         cap_code = '0;
         cap_csum = '0;
         cap_proto = '0;
         quoted_ihl = '0;
         quoted_proto = '0;
         cap_sport = '0;
         cap_dport = '0;
         cap_seq = '0;
      end
   endtask

   task automatic send_request(icmp_rc_pkg::req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      classify_byte(r);
      bytes_sent++;
   endtask

   task automatic send_message(logic [7:0] first_proto);
      icmp_rc_pkg::req_type r;
      int i;
      for (i = 0; i < msg_bytes.size(); i++) begin
         r.data_byte = msg_bytes[i];
         r.last = (i == msg_bytes.size() - 1);
         r.ip_protocol = (i == 0) ? first_proto : rand_byte();
         send_request(r);
      end
      messages_sent++;
   endtask

   task automatic start_message(logic [7:0] msg_type, logic [7:0] msg_code, int body_len);
      msg_bytes.delete();
      msg_bytes.push_back(msg_type);
      msg_bytes.push_back(msg_code);
      msg_bytes.push_back(8'h00);
      msg_bytes.push_back(8'h00);
      repeat (4 + body_len) msg_bytes.push_back(rand_byte());
   endtask

   task automatic trim_message(int keep);
      while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
   endtask

   // quoted ipv4 header plus transport bytes, qlen bytes in all
   task automatic add_quote(logic [3:0] ihl, logic [7:0] iproto, int qlen);
      int i;
      for (i = 0; i < qlen; i++) begin
         if (i == 0) msg_bytes.push_back({4'h4, ihl});
         else msg_bytes.push_back(rand_byte());
      end
      if (msg_bytes.size() > icmp_rc_pkg::HDR_BYTES + 9)
         msg_bytes[icmp_rc_pkg::HDR_BYTES + 9] = iproto;
   endtask

   task automatic seal_checksum();
      logic [15:0] acc;
      int i;
      msg_bytes[2] = 8'h00;
      msg_bytes[3] = 8'h00;
      acc = '0;
      for (i = 0; i < msg_bytes.size(); i += 2)
         acc = ones_add(acc, {msg_bytes[i],
                              (i + 1 < msg_bytes.size()) ? msg_bytes[i + 1] : 8'h00});
      msg_bytes[2] = ~acc[15:8];
      msg_bytes[3] = ~acc[7:0];
   endtask

   task automatic send_simple(logic [7:0] msg_type, logic [7:0] msg_code, int body_len);
      start_message(msg_type, msg_code, body_len);
      seal_checksum();
      send_message(icmp_rc_pkg::PROTO_ICMP);
   endtask

   task automatic send_error(logic [7:0] msg_type, logic [7:0] msg_code, logic [3:0] ihl,
                             logic [7:0] iproto, int qlen);
      start_message(msg_type, msg_code, 0);
      add_quote(ihl, iproto, qlen);
      seal_checksum();
      send_message(icmp_rc_pkg::PROTO_ICMP);
   endtask

   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (verdict_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_limits(logic [7:0] icmp_min, logic [7:0] tcp_min, logic [7:0] udp_min);
      csr_write_enable <= 1'b1;
      csr_index <= icmp_rc_pkg::CSR_ICMP_MIN;
      csr_write_data <= icmp_min;
      @(posedge clock);
      min_icmp_payload = icmp_min;
      csr_index <= icmp_rc_pkg::CSR_TCP_MIN;
      csr_write_data <= tcp_min;
      @(posedge clock);
      min_tcp_payload = tcp_min;
      csr_index <= icmp_rc_pkg::CSR_UDP_MIN;
      csr_write_data <= udp_min;
      @(posedge clock);
      min_udp_payload = udp_min;
      csr_write_enable <= 1'b0;
   endtask

   task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
      error_count++;
      if (error_count <= 10)
         $display("verdict %0d: %s expected %0h, got %0h", verdicts_checked, name, want, got);
   endtask

   always @(posedge clock) begin : check_verdicts
      icmp_rc_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         if (rsp_valid && !rsp_stall) begin
            if (verdict_queue.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected verdict %0h with nothing pending", rsp_payload.verdict);
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_payload.verdict !== want.verdict)
                  report_field("verdict", want.verdict, rsp_payload.verdict);
               if (rsp_payload.error_kind !== want.error_kind)
                  report_field("error_kind", want.error_kind, rsp_payload.error_kind);
               if (rsp_payload.msg_type !== want.msg_type)
                  report_field("msg_type", want.msg_type, rsp_payload.msg_type);
               if (rsp_payload.msg_code !== want.msg_code)
                  report_field("msg_code", want.msg_code, rsp_payload.msg_code);
               if (rsp_payload.reply_checksum !== want.reply_checksum)
                  report_field("reply_checksum", want.reply_checksum, rsp_payload.reply_checksum);
               if (rsp_payload.embedded_proto !== want.embedded_proto)
                  report_field("embedded_proto", want.embedded_proto, rsp_payload.embedded_proto);
               if (rsp_payload.embedded_src_port !== want.embedded_src_port)
                  report_field("embedded_src_port", want.embedded_src_port,
                               rsp_payload.embedded_src_port);
               if (rsp_payload.embedded_dst_port !== want.embedded_dst_port)
                  report_field("embedded_dst_port", want.embedded_dst_port,
                               rsp_payload.embedded_dst_port);
               if (rsp_payload.embedded_seq !== want.embedded_seq)
                  report_field("embedded_seq", want.embedded_seq, rsp_payload.embedded_seq);
               if (rsp_payload.embedded_payload_len !== want.embedded_payload_len)
                  report_field("embedded_payload_len", want.embedded_payload_len,
                               rsp_payload.embedded_payload_len);
               verdicts_checked++;
            end
         end
      end
   end

   task automatic test_basic_verdicts();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      // too short, one byte and seven bytes
      start_message(icmp_rc_pkg::TYPE_ECHO_REQUEST, CODE_DEFAULT, 0);
      trim_message(1);
      send_message(icmp_rc_pkg::PROTO_ICMP);
      start_message(icmp_rc_pkg::TYPE_ECHO_REQUEST, CODE_DEFAULT, 0);
      trim_message(7);
      send_message(icmp_rc_pkg::PROTO_ICMP);
      // wrong ip protocol
      start_message(icmp_rc_pkg::TYPE_ECHO_REQUEST, CODE_DEFAULT, 6);
      seal_checksum();
      send_message(icmp_rc_pkg::PROTO_TCP);
      // corrupted body
      start_message(icmp_rc_pkg::TYPE_ECHO_REQUEST, CODE_DEFAULT, 10);
      seal_checksum();
      msg_bytes[12] = msg_bytes[12] ^ 8'h5a;
      send_message(icmp_rc_pkg::PROTO_ICMP);
      // zero checksum field skips verification
      start_message(icmp_rc_pkg::TYPE_ECHO_REQUEST, CODE_DEFAULT, 5);
      send_message(icmp_rc_pkg::PROTO_ICMP);
      send_simple(icmp_rc_pkg::TYPE_ECHO_REQUEST, CODE_DEFAULT, 3);
      send_simple(icmp_rc_pkg::TYPE_ECHO_REPLY, CODE_DEFAULT, 4);
      send_simple(icmp_rc_pkg::TYPE_ECHO_REPLY, 8'd7, 0);
      send_simple(icmp_rc_pkg::TYPE_ECHO_REQUEST, 8'd1, 0);
      send_simple(icmp_rc_pkg::TYPE_DEST_UNREACH, 8'd6, 0);
      send_simple(icmp_rc_pkg::TYPE_TIME_EXCEEDED, 8'd2, 0);
      send_simple(icmp_rc_pkg::TYPE_DEST_UNREACH, 8'd255, 0);
      send_simple(icmp_rc_pkg::TYPE_DEST_UNREACH, 8'd0, 0);
      send_simple(icmp_rc_pkg::TYPE_DEST_UNREACH, 8'd1, 0);
      send_simple(icmp_rc_pkg::TYPE_DEST_UNREACH, 8'd2, 0);
      send_simple(icmp_rc_pkg::TYPE_DEST_UNREACH, 8'd4, 0);
      send_simple(icmp_rc_pkg::TYPE_DEST_UNREACH, CODE_LAST_UNHANDLED, 0);
      send_simple(icmp_rc_pkg::TYPE_TIME_EXCEEDED, icmp_rc_pkg::CODE_FRAG_REASSEMBLY, 0);
      send_simple(8'd13, 8'd0, 2);
      send_simple(8'd255, 8'd255, 1);
   endtask

   task automatic test_quoted_headers();
      send_error(icmp_rc_pkg::TYPE_DEST_UNREACH, icmp_rc_pkg::CODE_PORT_UNREACH, 4'd5,
                 icmp_rc_pkg::PROTO_UDP, 28);
      send_error(icmp_rc_pkg::TYPE_DEST_UNREACH, icmp_rc_pkg::CODE_PORT_UNREACH, 4'd5,
                 icmp_rc_pkg::PROTO_TCP, 28);
      send_error(icmp_rc_pkg::TYPE_DEST_UNREACH, icmp_rc_pkg::CODE_PORT_UNREACH, 4'd5,
                 icmp_rc_pkg::PROTO_ICMP, 28);
      send_error(icmp_rc_pkg::TYPE_DEST_UNREACH, icmp_rc_pkg::CODE_PORT_UNREACH, 4'd5,
                 8'd2, 28);
      send_error(icmp_rc_pkg::TYPE_TIME_EXCEEDED, icmp_rc_pkg::CODE_TTL_IN_TRANSIT, 4'd5,
                 icmp_rc_pkg::PROTO_TCP, 30);
      // quoted data under 20 bytes, and under the quoted header length
      send_error(icmp_rc_pkg::TYPE_DEST_UNREACH, icmp_rc_pkg::CODE_PORT_UNREACH, 4'd5,
                 icmp_rc_pkg::PROTO_UDP, 19);
      send_error(icmp_rc_pkg::TYPE_TIME_EXCEEDED, icmp_rc_pkg::CODE_TTL_IN_TRANSIT, 4'd15,
                 icmp_rc_pkg::PROTO_UDP, 40);
      // payload just below the limit
      send_error(icmp_rc_pkg::TYPE_DEST_UNREACH, icmp_rc_pkg::CODE_PORT_UNREACH, 4'd5,
                 icmp_rc_pkg::PROTO_TCP, 27);
      // header length field below five, and at its largest value of fifteen
      send_error(icmp_rc_pkg::TYPE_DEST_UNREACH, icmp_rc_pkg::CODE_PORT_UNREACH, 4'd2,
                 icmp_rc_pkg::PROTO_UDP, 28);
      send_error(icmp_rc_pkg::TYPE_TIME_EXCEEDED, icmp_rc_pkg::CODE_TTL_IN_TRANSIT, 4'd0,
                 icmp_rc_pkg::PROTO_TCP, 24);
      send_error(icmp_rc_pkg::TYPE_DEST_UNREACH, icmp_rc_pkg::CODE_PORT_UNREACH, 4'd15,
                 icmp_rc_pkg::PROTO_ICMP, 68);
   endtask

   task automatic test_limit_extremes();
      wait_until_idle();
      set_limits(8'd0, 8'd0, 8'd0);
      // transport bytes partly or wholly missing
      send_error(icmp_rc_pkg::TYPE_DEST_UNREACH, icmp_rc_pkg::CODE_PORT_UNREACH, 4'd5,
                 icmp_rc_pkg::PROTO_ICMP, 20);
      send_error(icmp_rc_pkg::TYPE_DEST_UNREACH, icmp_rc_pkg::CODE_PORT_UNREACH, 4'd5,
                 icmp_rc_pkg::PROTO_TCP, 22);
      send_error(icmp_rc_pkg::TYPE_TIME_EXCEEDED, icmp_rc_pkg::CODE_TTL_IN_TRANSIT, 4'd5,
                 icmp_rc_pkg::PROTO_UDP, 20);
      send_error(icmp_rc_pkg::TYPE_DEST_UNREACH, icmp_rc_pkg::CODE_PORT_UNREACH, 4'd5,
                 icmp_rc_pkg::PROTO_UDP, 21);
      wait_until_idle();
      set_limits(8'd255, 8'd255, 8'd255);
      // payload below a limit of 255
      send_error(icmp_rc_pkg::TYPE_DEST_UNREACH, icmp_rc_pkg::CODE_PORT_UNREACH, 4'd5,
                 icmp_rc_pkg::PROTO_TCP, 28);
      send_error(icmp_rc_pkg::TYPE_TIME_EXCEEDED, icmp_rc_pkg::CODE_TTL_IN_TRANSIT, 4'd5,
                 icmp_rc_pkg::PROTO_ICMP, 40);
      send_error(icmp_rc_pkg::TYPE_DEST_UNREACH, icmp_rc_pkg::CODE_PORT_UNREACH, 4'd5,
                 icmp_rc_pkg::PROTO_UDP, 28);
   endtask

   task automatic test_random_traffic(int send_pct, int stall_pct);
      int start_bytes;
      int pick;
      int qlen;
      int k;
      logic [3:0] ihl;
      logic [7:0] iproto;
      logic [7:0] mtype;
      logic [7:0] mcode;
      wait_until_idle();
      set_limits(8'($urandom_range(20)), 8'($urandom_range(20)), 8'($urandom_range(20)));
      send_idle_pct = send_pct;
      recv_stall_pct = stall_pct;
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < RANDOM_PHASE_BYTES) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            mtype = $urandom_range(1) ? icmp_rc_pkg::TYPE_ECHO_REQUEST
                                      : icmp_rc_pkg::TYPE_ECHO_REPLY;
            mcode = ($urandom_range(9) == 0) ? rand_byte() : CODE_DEFAULT;
            start_message(mtype, mcode, $urandom_range(24));
            if ($urandom_range(9) != 0) seal_checksum();
            if ($urandom_range(9) == 0) begin
               k = $urandom_range(msg_bytes.size() - 1);
               msg_bytes[k] = msg_bytes[k] ^ 8'($urandom_range(1, 255));
            end
            send_message(($urandom_range(19) == 0) ? rand_byte() : icmp_rc_pkg::PROTO_ICMP);
         end else if (pick < 70) begin
            ihl = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'd5;
            case ($urandom_range(3))
               0: iproto = icmp_rc_pkg::PROTO_ICMP;
               1: iproto = icmp_rc_pkg::PROTO_TCP;
               2: iproto = icmp_rc_pkg::PROTO_UDP;
               default: iproto = rand_byte();
            endcase
            if ($urandom_range(3) == 0) qlen = $urandom_range(44);
            else qlen = int'(ihl) * 4 + $urandom_range(20);
            mtype = $urandom_range(1) ? icmp_rc_pkg::TYPE_DEST_UNREACH
                                      : icmp_rc_pkg::TYPE_TIME_EXCEEDED;
            mcode = (mtype == icmp_rc_pkg::TYPE_DEST_UNREACH) ? icmp_rc_pkg::CODE_PORT_UNREACH
                                                              : icmp_rc_pkg::CODE_TTL_IN_TRANSIT;
            start_message(mtype, mcode, 0);
            add_quote(ihl, iproto, qlen);
            if ($urandom_range(3) == 0 && msg_bytes.size() > icmp_rc_pkg::HDR_BYTES)
               msg_bytes[icmp_rc_pkg::HDR_BYTES] = {4'($urandom_range(15)), ihl};
            seal_checksum();
            if ($urandom_range(19) == 0) begin
               k = $urandom_range(msg_bytes.size() - 1);
               msg_bytes[k] = msg_bytes[k] ^ 8'($urandom_range(1, 255));
            end
            send_message(icmp_rc_pkg::PROTO_ICMP);
         end else if (pick < 80) begin
            case ($urandom_range(4))
               0: mtype = icmp_rc_pkg::TYPE_ECHO_REPLY;
               1: mtype = icmp_rc_pkg::TYPE_DEST_UNREACH;
               2: mtype = icmp_rc_pkg::TYPE_ECHO_REQUEST;
               3: mtype = icmp_rc_pkg::TYPE_TIME_EXCEEDED;
               default: mtype = rand_byte();
            endcase
            mcode = $urandom_range(1) ? 8'($urandom_range(7)) : rand_byte();
            send_simple(mtype, mcode, $urandom_range(12));
         end else if (pick < 90) begin
            k = $urandom_range(1, 12);
            start_message(icmp_rc_pkg::TYPE_ECHO_REQUEST, CODE_DEFAULT, 4);
            trim_message(k);
            if (k >= 4) seal_checksum();
            send_message($urandom_range(1) ? icmp_rc_pkg::PROTO_ICMP : rand_byte());
         end else begin
            msg_bytes.delete();
            repeat ($urandom_range(1, 40)) msg_bytes.push_back(rand_byte());
            send_message($urandom_range(1) ? icmp_rc_pkg::PROTO_ICMP : rand_byte());
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_basic_verdicts();
      test_quoted_headers();
      test_limit_extremes();
      test_random_traffic(0, 0);
      test_random_traffic(49, 0);
      test_random_traffic(0, 49);
      test_random_traffic(36, 36);
      req_valid <= 1'b0;
      while (verdict_queue.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (verdict_queue.size() != 0) error_count += verdict_queue.size();
      $display("sent %0d request bytes in %0d messages, checked %0d verdicts",
               bytes_sent, messages_sent, verdicts_checked);
      $display("payload limits at 0, 8, 255 and random; sender gaps and receiver stalls mixed in");
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #16000000;
      $display("timeout with %0d verdicts pending", verdict_queue.size());
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire

>>> files.f
design/icmp_rc_pkg.sv
design/icmp_rc_verdict.sv
design/icmp_receive_classifier.sv
test/tb_icmp_receive_classifier.sv
